### rtl/pcfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfp_pkg: shared widths, register indexes and helpers
// Fixed-point widths of the point-charge field pipeline, configuration
// register indexes and reset values, the per-item tag and output saturation.
// ----------------------------------------------------------------------------
package pcfp_pkg;

    localparam int CRD_W   = 24;   // Q8.16 coordinates, charge, min distance
    localparam int DIF_W   = 25;   // offset magnitude
    localparam int SQ_W    = 50;   // sum of squares
    localparam int ROOT_W  = 25;   // distance
    localparam int SCALE_W = 32;
    localparam int KMAG_W  = 56;   // |charge| * scale
    localparam int KHALF_W = 28;
    localparam int DEN_W   = 75;   // distance cubed
    localparam int NUM_W   = 89;   // offset * k * 2^8
    localparam int DVP_W   = 33;   // distance * 2^8
    localparam int Q_W     = 31;   // quotient bits below the saturation point
    localparam int CMP_W   = 106;  // field divider compare width
    localparam int PCMP_W  = 64;   // potential divider compare width
    localparam int OUT_W   = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_D  = 3'd5;

    localparam logic [CRD_W-1:0]   RST_CHARGE = 24'd65536;
    localparam logic [SCALE_W-1:0] RST_SCALE  = 32'd16777216;
    localparam logic [CRD_W-1:0]   RST_MIN_D  = 24'd6554;

    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] dneg;   // offset sign per axis
        logic       kneg;   // charge sign
        logic       kzero;  // charge times scale is zero
        logic       zero;   // clamped distance is zero
    } t_tag;

    function automatic logic [OUT_W-1:0] sat_out(input logic over,
                                                 input logic [Q_W-1:0] mag,
                                                 input logic neg);
        logic [OUT_W-1:0] ext;
        ext = {1'b0, mag};
        if (over) begin
            return neg ? SAT_NEG : SAT_POS;
        end
        return neg ? (~ext + OUT_W'(1)) : ext;
    endfunction

endpackage
`default_nettype wire

### rtl/point_charge_field_potential.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_charge_field_potential: Coulomb point-charge field and potential
// Evaluates field vector and potential of one configured charge at a stream
// of query points.
// ----------------------------------------------------------------------------
// One query point is accepted per clock and one result leaves per clock, as
// long as the output buffer is not full and the sink is ready. The pipeline
// depth is set by the square root (one root bit per stage, 25 stages) and the
// dividers (one quotient bit per stage, 31 stages). A two-entry
// output buffer lets the pipeline keep taking points while a result waits.
// Configuration registers may only be written while no point is in flight.
module point_charge_field_potential (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [pcfp_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire logic [pcfp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // point_x [23:0], point_y [47:24], point_z [71:48]
    input  wire logic [pcfp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // field_x [31:0], field_y [63:32], field_z [95:64], potential [127:96]
    output logic [pcfp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);
    import pcfp_pkg::*;

    localparam int NSQ   = ROOT_W;
    localparam int NDIV  = Q_W;
    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_SQ = 3;
    localparam int ST_D  = ST_SQ + NSQ;
    localparam int ST_E  = ST_D + 1;
    localparam int ST_F  = ST_E + 1;
    localparam int ST_G  = ST_F + 1;
    localparam int ST_H  = ST_G + 1;
    localparam int ST_Z  = ST_H + NDIV + 1;
    localparam int NSTG  = ST_Z + 1;

    // Configuration registers.
    logic [CRD_W-1:0]   r_pos [3];
    logic [CRD_W-1:0]   r_charge;
    logic [SCALE_W-1:0] r_scale;
    logic [CRD_W-1:0]   r_min_d;

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic            w_en;
    t_tag            r_tag [NSTG-1];

    // Offset, charge and squares.
    logic [DIF_W-1:0]  r_dm   [ST_E+1][3];
    logic [KMAG_W-1:0] r_kmag [ST_G+1];
    logic [SQ_W-1:0]   r_sq   [3];
    logic [SQ_W-1:0]   r_sum;

    // Square root.
    logic [SQ_W-1:0]   r_srem [NSQ];
    logic [ROOT_W-1:0] r_root [NSQ];
    logic [SQ_W-1:0]   n_srem [NSQ];
    logic [ROOT_W-1:0] n_root [NSQ];

    // Distance clamped to the configured minimum.
    logic [ROOT_W-1:0] n_len;

    // Distance powers and numerators.
    logic [ROOT_W-1:0]        r_len_d, r_len_e, r_len_f;
    logic [SQ_W-1:0]          r_len2, r_plo, r_phi;
    logic [KMAG_W-KHALF_W+DIF_W-1:0] r_nlo [3];
    logic [KMAG_W-KHALF_W+DIF_W-1:0] r_nhi [3];
    logic [DEN_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_num [3];
    logic [DVP_W-1:0]         r_dvp;

    // Dividers: index 0 is the overflow check stage, then one bit per stage.
    logic [NUM_W-1:0]  r_frem  [NDIV+1][3];
    logic [Q_W-1:0]    r_fq    [NDIV+1][3];
    logic [2:0]        r_fover [NDIV+1];
    logic [KMAG_W-1:0] r_prem  [NDIV+1];
    logic [Q_W-1:0]    r_pq    [NDIV+1];
    logic              r_pover [NDIV+1];
    logic [DEN_W-1:0]  r_den_p [NDIV+1];
    logic [DVP_W-1:0]  r_dvp_p [NDIV+1];
    logic [NUM_W-1:0]  n_frem  [NDIV+1][3];
    logic [Q_W-1:0]    n_fq    [NDIV+1][3];
    logic [KMAG_W-1:0] n_prem  [NDIV+1];
    logic [Q_W-1:0]    n_pq    [NDIV+1];

    // Output stage and buffer.
    logic [OUT_TDATA_W-1:0] r_z_data;
    logic [OUT_TDATA_W-1:0] n_z_data;
    logic [OUT_TDATA_W-1:0] r_fifo [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   w_push, w_pop;

    // Input stage combinational terms.
    logic [CRD_W-1:0]  w_pt    [3];
    logic [DIF_W-1:0]  w_diff  [3];
    logic [DIF_W-1:0]  w_dmag  [3];
    logic [CRD_W-1:0]  w_cmag;
    logic [KMAG_W-1:0] w_kmag;

    assign w_en          = !r_vld[ST_Z] || (r_cnt != 2'd2);
    assign s_axis_tready = w_en;
    assign w_push        = w_en && r_vld[ST_Z];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_fifo[r_rp];

    always_comb begin
        w_pt[0] = s_axis_tdata[CRD_W-1:0];
        w_pt[1] = s_axis_tdata[2*CRD_W-1:CRD_W];
        w_pt[2] = s_axis_tdata[3*CRD_W-1:2*CRD_W];
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = {w_pt[a][CRD_W-1], w_pt[a]} - {r_pos[a][CRD_W-1], r_pos[a]};
            w_dmag[a] = w_diff[a][DIF_W-1] ? (~w_diff[a] + DIF_W'(1)) : w_diff[a];
        end
        w_cmag = r_charge[CRD_W-1] ? (~r_charge + CRD_W'(1)) : r_charge;
        w_kmag = KMAG_W'(w_cmag) * KMAG_W'(r_scale);
    end

    // Square root: each stage decides one root bit from the top down.
    always_comb begin
        logic [SQ_W-1:0]   rin;
        logic [ROOT_W-1:0] rt;
        logic [SQ_W:0]     trial;
        int                b;
        for (int s = 0; s < NSQ; s++) begin
            b     = NSQ - 1 - s;
            rin   = (s == 0) ? r_sum : r_srem[(s == 0) ? 0 : s - 1];
            rt    = (s == 0) ? '0 : r_root[(s == 0) ? 0 : s - 1];
            trial = ((SQ_W + 1)'(rt) << (b + 1)) + ((SQ_W + 1)'(1) << (2 * b));
            if ({1'b0, rin} >= trial) begin
                n_srem[s] = rin - trial[SQ_W-1:0];
                n_root[s] = rt | (ROOT_W'(1) << b);
            end else begin
                n_srem[s] = rin;
                n_root[s] = rt;
            end
        end
    end

    // Restoring dividers, one quotient bit per stage.
    always_comb begin
        logic [CMP_W-1:0]  fsh;
        logic [PCMP_W-1:0] psh;
        int                b;
        for (int h = 0; h <= NDIV; h++) begin
            b = NDIV - h;
            if (h == 0) begin
                for (int a = 0; a < 3; a++) begin
                    n_frem[h][a] = r_num[a];
                    n_fq[h][a]   = '0;
                end
                n_prem[h] = r_kmag[ST_G];
                n_pq[h]   = '0;
            end else begin
                fsh = CMP_W'(r_den_p[h-1]) << b;
                for (int a = 0; a < 3; a++) begin
                    if (CMP_W'(r_frem[h-1][a]) >= fsh) begin
                        n_frem[h][a] = NUM_W'(CMP_W'(r_frem[h-1][a]) - fsh);
                        n_fq[h][a]   = r_fq[h-1][a] | (Q_W'(1) << b);
                    end else begin
                        n_frem[h][a] = r_frem[h-1][a];
                        n_fq[h][a]   = r_fq[h-1][a];
                    end
                end
                psh = PCMP_W'(r_dvp_p[h-1]) << b;
                if (PCMP_W'(r_prem[h-1]) >= psh) begin
                    n_prem[h] = KMAG_W'(PCMP_W'(r_prem[h-1]) - psh);
                    n_pq[h]   = r_pq[h-1] | (Q_W'(1) << b);
                end else begin
                    n_prem[h] = r_prem[h-1];
                    n_pq[h]   = r_pq[h-1];
                end
            end
        end
    end

    // Output formatting; a zero distance forces the field to zero.
    always_comb begin
        t_tag tg;
        tg = r_tag[ST_Z-1];
        for (int a = 0; a < 3; a++) begin
            n_z_data[a*OUT_W +: OUT_W] = tg.zero ? '0 :
                sat_out(r_fover[NDIV][a], r_fq[NDIV][a],
                        (tg.dneg[a] ^ tg.kneg) &&
                        (r_fover[NDIV][a] || (r_fq[NDIV][a] != '0)));
        end
        n_z_data[3*OUT_W +: OUT_W] = (tg.zero && tg.kzero) ? '0 :
            sat_out(r_pover[NDIV], r_pq[NDIV],
                    tg.kneg && (r_pover[NDIV] || (r_pq[NDIV] != '0)));
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k < NSTG - 1; k++) begin
                if (k == ST_D) begin
                    r_tag[k] <= '{dneg: r_tag[k-1].dneg, kneg: r_tag[k-1].kneg,
                                  kzero: r_tag[k-1].kzero, zero: (n_len == '0)};
                end else begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
            r_tag[ST_A] <= '{dneg: {w_diff[2][DIF_W-1], w_diff[1][DIF_W-1],
                                    w_diff[0][DIF_W-1]},
                             kneg: r_charge[CRD_W-1], kzero: (w_kmag == '0),
                             zero: 1'b0};

            r_dm[ST_A]   <= w_dmag;
            r_kmag[ST_A] <= w_kmag;
            for (int k = 1; k <= ST_E; k++) begin
                r_dm[k] <= r_dm[k-1];
            end
            for (int k = 1; k <= ST_G; k++) begin
                r_kmag[k] <= r_kmag[k-1];
            end

            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= SQ_W'(r_dm[ST_A][a]) * SQ_W'(r_dm[ST_A][a]);
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];

            r_srem <= n_srem;
            r_root <= n_root;

            r_len_d <= n_len;
            r_len_e <= r_len_d;
            r_len2  <= SQ_W'(r_len_d) * SQ_W'(r_len_d);
            r_len_f <= r_len_e;
            r_plo   <= SQ_W'(r_len2[ROOT_W-1:0]) * SQ_W'(r_len_e);
            r_phi   <= SQ_W'(r_len2[SQ_W-1:ROOT_W]) * SQ_W'(r_len_e);
            for (int a = 0; a < 3; a++) begin
                r_nlo[a] <= (KMAG_W-KHALF_W+DIF_W)'(r_dm[ST_E][a]) *
                            (KMAG_W-KHALF_W+DIF_W)'(r_kmag[ST_E][KHALF_W-1:0]);
                r_nhi[a] <= (KMAG_W-KHALF_W+DIF_W)'(r_dm[ST_E][a]) *
                            (KMAG_W-KHALF_W+DIF_W)'(r_kmag[ST_E][KMAG_W-1:KHALF_W]);
                r_num[a] <= (NUM_W'(r_nhi[a]) << (KHALF_W + 8)) + (NUM_W'(r_nlo[a]) << 8);
            end
            r_den <= DEN_W'(r_plo) + (DEN_W'(r_phi) << ROOT_W);
            r_dvp <= {r_len_f, 8'b0};

            r_frem <= n_frem;
            r_fq   <= n_fq;
            r_prem <= n_prem;
            r_pq   <= n_pq;
            for (int a = 0; a < 3; a++) begin
                r_fover[0][a] <= CMP_W'(r_num[a]) >= (CMP_W'(r_den) << Q_W);
            end
            r_pover[0] <= PCMP_W'(r_kmag[ST_G]) >= (PCMP_W'(r_dvp) << Q_W);
            r_den_p[0] <= r_den;
            r_dvp_p[0] <= r_dvp;
            for (int h = 1; h <= NDIV; h++) begin
                r_fover[h] <= r_fover[h-1];
                r_pover[h] <= r_pover[h-1];
                r_den_p[h] <= r_den_p[h-1];
                r_dvp_p[h] <= r_dvp_p[h-1];
            end

            r_z_data <= n_z_data;
        end
        if (w_push) begin
            r_fifo[r_wp] <= r_z_data;
        end
    end

    assign n_len = (r_root[NSQ-1] < ROOT_W'(r_min_d)) ? ROOT_W'(r_min_d) : r_root[NSQ-1];

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_charge <= RST_CHARGE;
            r_scale  <= RST_SCALE;
            r_min_d  <= RST_MIN_D;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_POS_X:  r_pos[0] <= i_cfg_wdata[CRD_W-1:0];
                    CFG_POS_Y:  r_pos[1] <= i_cfg_wdata[CRD_W-1:0];
                    CFG_POS_Z:  r_pos[2] <= i_cfg_wdata[CRD_W-1:0];
                    CFG_CHARGE: r_charge <= i_cfg_wdata[CRD_W-1:0];
                    CFG_SCALE:  r_scale  <= i_cfg_wdata[SCALE_W-1:0];
                    CFG_MIN_D:  r_min_d  <= i_cfg_wdata[CRD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for point_charge_field_potential
// Streams query points through the block under several charge settings and
// compares every field and potential result against an exact integer model,
// while both stream sides idle at random in most settings.
// ----------------------------------------------------------------------------
module tb;
    import pcfp_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [OUT_W-1:0] fx, fy, fz, pot;
    } t_field_result;

    class field_scoreboard;
        logic [CRD_W-1:0]   pos_x, pos_y, pos_z, charge, min_d;
        logic [SCALE_W-1:0] scale;
        t_field_result      expected_results[$];
        int                 errors;
        int                 checked;

        function new();
            pos_x = '0;
            pos_y = '0;
            pos_z = '0;
            charge = RST_CHARGE;
            scale = RST_SCALE;
            min_d = RST_MIN_D;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_POS_X:  pos_x = val[CRD_W-1:0];
                CFG_POS_Y:  pos_y = val[CRD_W-1:0];
                CFG_POS_Z:  pos_z = val[CRD_W-1:0];
                CFG_CHARGE: charge = val[CRD_W-1:0];
                CFG_SCALE:  scale = val;
                CFG_MIN_D:  min_d = val[CRD_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ROOT_W-1:0] floor_root(logic [SQ_W-1:0] v);
            logic [ROOT_W-1:0] r;
            logic [ROOT_W-1:0] c;
            r = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                c = r | (ROOT_W'(1) << b);
                if (SQ_W'(c) * SQ_W'(c) <= v) r = c;
            end
            return r;
        endfunction

        function logic [OUT_W-1:0] saturate(logic [127:0] q, logic neg);
            if (neg) return (q >= 128'h8000_0000) ? SAT_NEG : (~q[31:0] + 32'd1);
            return (q > 128'h7FFF_FFFF) ? SAT_POS : q[31:0];
        endfunction

        function void note_point(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py,
                                 logic [CRD_W-1:0] pz);
            logic signed [DIF_W-1:0] d[3];
            logic [DIF_W-1:0]        dm[3];
            logic [SQ_W-1:0]         sumsq;
            logic [ROOT_W-1:0]       len;
            logic [CRD_W-1:0]        cmag;
            logic [127:0]            kmag, den, q;
            logic                    kneg;
            logic [OUT_W-1:0]        f[3];
            t_field_result           r;
            d[0] = $signed({px[23], px}) - $signed({pos_x[23], pos_x});
            d[1] = $signed({py[23], py}) - $signed({pos_y[23], pos_y});
            d[2] = $signed({pz[23], pz}) - $signed({pos_z[23], pos_z});
            sumsq = '0;
            for (int i = 0; i < 3; i++) begin
                dm[i] = d[i] < 0 ? -d[i] : d[i];
                sumsq += SQ_W'(dm[i]) * SQ_W'(dm[i]);
            end
            len = floor_root(sumsq);
            if (len < ROOT_W'(min_d)) len = ROOT_W'(min_d);
            kneg = charge[23];
            cmag = kneg ? (~charge + 24'd1) : charge;
            kmag = 128'(cmag) * 128'(scale);
            if (len == 0) begin
                // Point on the charge with no clamp: field vanishes, potential pins.
                r.fx = '0;
                r.fy = '0;
                r.fz = '0;
                r.pot = kmag == 0 ? '0 : (kneg ? SAT_NEG : SAT_POS);
            end else begin
                den = 128'(len) * 128'(len) * 128'(len);
                for (int i = 0; i < 3; i++) begin
                    q = ((128'(dm[i]) << 8) * kmag) / den;
                    f[i] = saturate(q, (d[i] < 0) != kneg && q != 0);
                end
                r.fx = f[0];
                r.fy = f[1];
                r.fz = f[2];
                q = kmag / (128'(len) << 8);
                r.pot = saturate(q, kneg && q != 0);
            end
            expected_results.push_back(r);
        endfunction

        task report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h", what, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            t_field_result e;
            if (expected_results.size() == 0) begin
                report("unexpected result", data[31:0], '0);
                return;
            end
            e = expected_results.pop_front();
            checked++;
            if (data[31:0] !== e.fx) report("field_x", data[31:0], e.fx);
            if (data[63:32] !== e.fy) report("field_y", data[63:32], e.fy);
            if (data[95:64] !== e.fz) report("field_z", data[95:64], e.fz);
            if (data[127:96] !== e.pot) report("potential", data[127:96], e.pot);
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    field_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycles = 0;
    int points_sent = 0;

    point_charge_field_potential dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    task send_point(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py, logic [CRD_W-1:0] pz);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pz, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_point(px, py, pz);
        points_sent++;
    endtask

    // Registers change only after the pipeline has drained completely.
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task write_regs(logic [CFG_DATA_W-1:0] v[8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= CFG_IDX_W'(i);
            i_cfg_wdata <= v[i];
            @(posedge i_clk);
            sb.set_reg(CFG_IDX_W'(i), v[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [CRD_W-1:0] pick_coord(logic [CRD_W-1:0] center);
        case ($urandom_range(5))
            0: return CRD_W'($urandom);
            1: return center + CRD_W'($urandom_range(15)) - 24'd8;
            2: return center + CRD_W'($urandom_range(65535)) - 24'd32768;
            3: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return center + CRD_W'($signed($urandom) >>> $urandom_range(8, 22));
        endcase
    endfunction

    task random_points(int n);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(sb.pos_x), pick_coord(sb.pos_y), pick_coord(sb.pos_z));
    endtask

    logic [CFG_DATA_W-1:0] regs[8];

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under the reset settings: the origin, axis extremes,
        // corners and points just inside and outside the distance clamp.
        src_idle_pct = 38;
        sink_stall_pct = 81;
        send_point(24'd0, 24'd0, 24'd0);
        send_point(24'h7FFFFF, 24'd0, 24'd0);
        send_point(24'h800000, 24'd0, 24'd0);
        send_point(24'd0, 24'h7FFFFF, 24'd0);
        send_point(24'd0, 24'd0, 24'h800000);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_point(24'd6553, 24'd0, 24'd0);
        send_point(24'd6555, 24'd0, 24'd0);
        send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(24'd1, 24'd0, 24'd0);
        send_point(24'd65536, 24'd65536, 24'd65536);
        send_point(24'hFF0000, 24'd0, 24'd65536);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            src_idle_pct = ph < 3 ? 38 : (ph < 6 ? 81 : 0);
            sink_stall_pct = ph < 3 ? 81 : (ph < 6 ? 38 : 0);
            regs[0] = $urandom;
            regs[1] = $urandom;
            regs[2] = $urandom;
            regs[3] = $urandom;
            regs[4] = $urandom;
            regs[5] = $urandom_range(1) ? $urandom_range(200000) : $urandom;
            regs[6] = $urandom;
            regs[7] = $urandom;
            case (ph)
                0: begin
                    regs[3] = 32'h0080_0000;
                    regs[4] = 32'hFFFF_FFFF;
                    regs[5] = '0;
                end
                1: begin
                    regs[3] = 32'h007F_FFFF;
                    regs[4] = '0;
                    regs[5] = 32'hFFFF_FFFF;
                end
                2: begin
                    regs[3] = '0;
                    regs[5] = '0;
                end
                3: begin
                    regs[0] = 32'h7FFFFF;
                    regs[1] = 32'h800000;
                    regs[2] = 32'h7FFFFF;
                    regs[5] = 32'd1;
                end
                4: begin
                    regs[5] = '0;
                    regs[4] = 32'hFFFF_FFFF;
                end
                5: regs[4] = $urandom_range(1 << 20);
                6: begin
                    regs[3] = 32'h0080_0000;
                    regs[5] = '0;
                end
                default: ;
            endcase
            write_regs(regs);
            // Start each setting at the charge itself and one step away.
            send_point(sb.pos_x, sb.pos_y, sb.pos_z);
            send_point(sb.pos_x + 24'd1, sb.pos_y, sb.pos_z);
            send_point(sb.pos_x, sb.pos_y - 24'd1, sb.pos_z + 24'd1);
            random_points(ph == 8 ? 180 : 100);
            drain();
        end

        $display("Ran %0d query points through 10 charge settings,", points_sent);
        $display("%0d results compared, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/pcfp_pkg.sv
rtl/point_charge_field_potential.sv
sim/tb.sv
